// ===== hdl/cbmm_pkg.sv =====
package cbmm_pkg;

  // Result kinds on the master side
  typedef enum logic [2:0] {
    TGT_NONE   = 3'd0,
    TGT_WRAM   = 3'd1,
    TGT_SRAM   = 3'd2,
    TGT_ROM    = 3'd3,
    TGT_PORT   = 3'd4,
    TGT_IO     = 3'd5,
    TGT_DMAEN  = 3'd6,
    TGT_DMAREG = 3'd7
  } target_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_MAPPING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE    = 2'd1;

  // ROM mapping codes
  localparam logic [2:0] MAP_LOW      = 3'd0;
  localparam logic [2:0] MAP_HIGH     = 3'd1;
  localparam logic [2:0] MAP_EXT_LOW  = 3'd2;
  localparam logic [2:0] MAP_EXT_HIGH = 3'd3;
  localparam logic [2:0] MAP_NONE     = 3'd4;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Field widths
  localparam int ADDR_W   = 24;
  localparam int DATA_W   = 8;
  localparam int OFFSET_W = 22;
  localparam int SIZE_W   = 23;

  // Address map
  localparam logic [6:0]  WRAM_BANK_HI = 7'h3F;  // banks 7E and 7F
  localparam logic [15:0] LOW_WRAM_END = 16'h2000;
  localparam logic [15:0] PORT_BASE    = 16'h2140;
  localparam logic [15:0] PORT_END     = 16'h2144;
  localparam logic [15:0] IO_B_BASE    = 16'h2100;
  localparam logic [15:0] IO_B_END     = 16'h2200;
  localparam logic [15:0] IO_C_BASE    = 16'h4200;
  localparam logic [15:0] IO_C_END     = 16'h4220;
  localparam logic [15:0] DMA_EN_ADDR  = 16'h420B;
  localparam logic [15:0] HDMA_EN_ADDR = 16'h420C;
  localparam logic [15:0] DMA_BASE     = 16'h4300;
  localparam logic [15:0] DMA_END      = 16'h4380;
  localparam logic [15:0] SRAM_BASE    = 16'h6000;
  localparam logic [15:0] ROM_WINDOW   = 16'h8000;
  localparam logic [7:0]  SRAM_BANK_A  = 8'h70;
  localparam logic [7:0]  SRAM_BANK_B  = 8'hF0;

endpackage

// ===== hdl/cpu_bus_memory_map_top.sv =====
// CPU bus memory map decoder with internal work RAM and save RAM.
// Slave channel s_*: one bus access per transfer. s_tuser is the access kind
// (0 read, 1 write); s_tdata carries the address and the write byte.
// Master channel m_*: one result per access. m_tuser is the target kind;
// m_tdata carries the local offset and the read byte.
// Configuration channel cfg_*: always ready; index 0 sets the ROM mapping,
// index 1 the ROM size, other indexes are ignored. Write only while idle.
// Throughput: one access per cycle while m_tready is high. An accepted access
// passes through the decode stage, alongside the registered RAM read, and
// then the output register before m_tvalid rises.
// Writes to RAM take effect at the accepting edge, so a read that follows in
// the next cycle sees the new byte.
// Reset: both RAMs are zeroed by a clearing pass over the larger of the two,
// one byte of each per cycle, during which s_tready stays low. ROM mapping
// returns to none, size to 0.
// Stall: while m_tready is low the result is held; one further access is
// taken into the decode stage, then s_tready drops until the result drains.
module cpu_bus_memory_map_top
  import cbmm_pkg::*;
#(
  parameter int WORK_RAM_BYTES = 131072,
  parameter int SAVE_RAM_BYTES = 32768
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data,
  // Bus accesses
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // [23:0] bus_address, [31:24] write_data
  input  logic [0:0]             s_tuser,   // [0] cmd
  // Results
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // [21:0] local_offset, [29:22] read_data, [31:30] 0
  output logic [2:0]             m_tuser    // [2:0] target
);

  localparam int WA = $clog2(WORK_RAM_BYTES);
  localparam int SA = $clog2(SAVE_RAM_BYTES);
  localparam int CLEAR_BYTES = (WORK_RAM_BYTES > SAVE_RAM_BYTES) ?
                               WORK_RAM_BYTES : SAVE_RAM_BYTES;
  localparam int CLR_W = $clog2(CLEAR_BYTES);

  logic [2:0]        rom_mapping;
  logic [SIZE_W-1:0] rom_size;

  logic              clearing;
  logic [CLR_W-1:0]  clr_addr;

  logic [DATA_W-1:0] work_ram [WORK_RAM_BYTES];
  logic [DATA_W-1:0] save_ram [SAVE_RAM_BYTES];
  logic [DATA_W-1:0] wram_q;
  logic [DATA_W-1:0] sram_q;

  logic                s1_valid;
  target_t             s1_target;
  logic [OFFSET_W-1:0] s1_offset;
  logic                s1_rd_wram;
  logic                s1_rd_sram;

  logic                out_valid;
  target_t             out_target;
  logic [OFFSET_W-1:0] out_offset;
  logic [DATA_W-1:0]   out_rdata;

  logic              in_accept;
  logic              s1_move;
  logic              wr;
  logic [7:0]        bank;
  logic [15:0]       off;
  logic [DATA_W-1:0] wdata;
  logic              low_bank;
  logic              low_map;
  logic              high_map;
  logic              cont;
  logic [16:0]       sram_addr;
  logic [OFFSET_W-1:0] rom_addr;
  target_t             dec_target;
  logic [OFFSET_W-1:0] dec_offset;
  logic              wram_hit;
  logic              sram_hit;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_mapping <= MAP_NONE;
      rom_size    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROM_MAPPING: rom_mapping <= cfg_data[2:0];
        CFG_ROM_SIZE:    rom_size    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (32'(clr_addr) == CLEAR_BYTES - 1) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Handshake
  assign s1_move   = !out_valid || m_tready;
  assign s_tready  = !clearing && (!s1_valid || s1_move);
  assign in_accept = s_tvalid && s_tready;

  assign wr    = s_tuser[0] == CMD_WRITE;
  assign bank  = s_tdata[23:16];
  assign off   = s_tdata[15:0];
  assign wdata = s_tdata[31:24];

  assign low_bank  = !bank[6];
  assign low_map   = (rom_mapping == MAP_LOW) || (rom_mapping == MAP_EXT_LOW);
  assign high_map  = (rom_mapping == MAP_HIGH) || (rom_mapping == MAP_EXT_HIGH);
  assign sram_addr = {bank[3:0], off[12:0]};

  // Decode the address
  always_comb begin
    dec_target = TGT_NONE;
    dec_offset = '0;
    cont       = 1'b1;
    rom_addr   = '0;
    if (bank[7:1] == WRAM_BANK_HI) begin
      cont = 1'b0;
      if (32'(s_tdata[16:0]) < WORK_RAM_BYTES) begin
        dec_target = TGT_WRAM;
        dec_offset = OFFSET_W'(s_tdata[16:0]);
      end
    end else if (low_bank) begin
      if (off < LOW_WRAM_END) begin
        cont       = 1'b0;
        dec_target = TGT_WRAM;
        dec_offset = OFFSET_W'(off);
      end else if (off >= PORT_BASE && off < PORT_END) begin
        cont       = 1'b0;
        dec_target = TGT_PORT;
        dec_offset = OFFSET_W'(off[1:0]);
      end else if (off >= IO_B_BASE && off < IO_B_END) begin
        cont       = 1'b0;
        dec_target = TGT_IO;
        dec_offset = OFFSET_W'(off);
      end else if (off >= IO_C_BASE && off < IO_C_END) begin
        cont = 1'b0;
        if (wr && off == DMA_EN_ADDR) begin
          dec_target = TGT_DMAEN;
        end else if (!(wr && off == HDMA_EN_ADDR)) begin
          dec_target = TGT_IO;
          dec_offset = OFFSET_W'(off);
        end
      end else if (wr && off >= DMA_BASE && off < DMA_END) begin
        cont       = 1'b0;
        dec_target = TGT_DMAREG;
        dec_offset = OFFSET_W'(off[6:0]);
      end
    end
    // Save RAM window; out of range reads fall through to ROM
    if (cont && off >= SRAM_BASE && off < ROM_WINDOW &&
        (bank[7:4] == SRAM_BANK_A[7:4] || bank[7:4] == SRAM_BANK_B[7:4])) begin
      if (32'(sram_addr) < SAVE_RAM_BYTES) begin
        cont       = 1'b0;
        dec_target = TGT_SRAM;
        dec_offset = OFFSET_W'(sram_addr);
      end
    end
    // ROM, reads only
    if (cont && !wr && !(low_bank && off < ROM_WINDOW)) begin
      if (low_map) begin
        if (off >= ROM_WINDOW) begin
          rom_addr = {bank[6:0], off[14:0]};
          if ({1'b0, rom_addr} < rom_size) begin
            dec_target = TGT_ROM;
            dec_offset = rom_addr;
          end
        end
      end else if (high_map) begin
        rom_addr = {bank[5:0], off};
        if ({1'b0, rom_addr} < rom_size) begin
          dec_target = TGT_ROM;
          dec_offset = rom_addr;
        end
      end
    end
  end

  assign wram_hit = in_accept && dec_target == TGT_WRAM;
  assign sram_hit = in_accept && dec_target == TGT_SRAM;

  // Work RAM: clear sweep, write or registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (32'(clr_addr) < WORK_RAM_BYTES) begin
        work_ram[clr_addr[WA-1:0]] <= '0;
      end
    end else if (wram_hit && wr) begin
      work_ram[dec_offset[WA-1:0]] <= wdata;
    end
    if (wram_hit && !wr) begin
      wram_q <= work_ram[dec_offset[WA-1:0]];
    end
  end

  // Save RAM: clear sweep, write or registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (32'(clr_addr) < SAVE_RAM_BYTES) begin
        save_ram[clr_addr[SA-1:0]] <= '0;
      end
    end else if (sram_hit && wr) begin
      save_ram[dec_offset[SA-1:0]] <= wdata;
    end
    if (sram_hit && !wr) begin
      sram_q <= save_ram[dec_offset[SA-1:0]];
    end
  end

  // Decode stage, alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_target  <= dec_target;
      s1_offset  <= dec_offset;
      s1_rd_wram <= wram_hit && !wr;
      s1_rd_sram <= sram_hit && !wr;
    end
  end

  // Output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_target <= s1_target;
      out_offset <= s1_offset;
      if (s1_rd_wram) begin
        out_rdata <= wram_q;
      end else if (s1_rd_sram) begin
        out_rdata <= sram_q;
      end else begin
        out_rdata <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_target;
  assign m_tdata  = {2'b00, out_rdata, out_offset};

`ifndef SYNTHESIS
  // No access is taken while the RAMs are being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("access accepted during clearing pass");

  // Only RAM targets carry read data
  a_rdata_ram_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != TGT_WRAM && m_tuser != TGT_SRAM) |-> m_tdata[29:22] == '0)
    else $error("read data on a non-RAM result");

  // Unmapped results report offset zero
  a_none_offset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == TGT_NONE) |-> m_tdata[21:0] == '0)
    else $error("unmapped result with non-zero offset");

  // A stage that cannot drain keeps the input stalled
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("access accepted while decode stage is blocked");
`endif

endmodule
